@@ hdl/ihbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihbs_pkg
// shared types and constants of the source address hash back-end selector
// ----------------------------------------------------------------------------
package ihbs_pkg;

  localparam int ADDR_W    = 64;   // each address half
  localparam int TIME_W    = 32;   // coarse time
  localparam int TIMEOUT_W = 16;   // disable timeout register
  localparam int CNT_W     = 5;    // entry count register and counters
  localparam int ENTRY_W   = 4;    // entry index fields on the stream
  localparam int HASH_W    = 12;   // byte sum of up to sixteen bytes
  localparam int BYTE_W    = 8;
  localparam int ALU_W     = 32;   // shared unit operand width

  localparam logic [CNT_W-1:0] BYTES_V4 = 5'd4;
  localparam logic [CNT_W-1:0] BYTES_V6 = 5'd16;
  localparam logic [3:0]       HASH_STEPS = 4'd12;

  localparam int S_TDATA_W = 168;  // 164 field bits padded to bytes
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 8;    // 5 field bits padded to a byte

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISABLE_TIMEOUT = 1'd1;

  localparam logic CMD_DISPATCH = 1'b0;
  localparam logic CMD_REPORT   = 1'b1;

  localparam logic [4:0] RESET_ENTRY_COUNT = 5'd1;
  localparam logic [TIMEOUT_W-1:0] RESET_TIMEOUT = 16'd300;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_REM = 2'd1,
    ALU_GEQ = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic [ALU_W-1:0] value;
    logic             flag;
  } alu_res_t;

endpackage

@@ hdl/ip_hash_backend_selector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_hash_backend_selector
// picks a back-end entry for a client address by source address hash
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one request: s_tuser = {is_ipv6, command}, s_tdata = now,
//   failed_entry, addr_low, addr_high. command 0 dispatches the address and
//   returns the chosen entry; command 1 marks an entry failed until
//   now + disable_timeout and returns status 1 if the index is out of range.
//   m_* carries one result per request: chosen_entry and status.
//   cfg_we/cfg_index/cfg_wdata write entry_count (index 0, which also
//   re-enables every entry) and disable_timeout (index 1); write only idle.
// sequence:
//   a dispatch runs the shared unit one byte per cycle over 4 or 16 bytes,
//   then an all-disabled revival step, 12 restoring remainder steps, then
//   a walk over the entries in use until the pick is found. a report
//   skips the hash and the walk.
//   one request is in work at a time; s_tready is high only when idle.
// reset: all entries enabled, entry_count 1, disable_timeout 300.
// stall: the result sits in an output register; a new request is taken
//   while it waits, and the block holds in its last step until it drains.
// ----------------------------------------------------------------------------
module ip_hash_backend_selector
  import ihbs_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
)
(
  input  logic                  clk,
  input  logic                  rst,
  // stream in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // addr_high, addr_low, failed_entry, now, pad
  input  logic [S_TUSER_W-1:0]  s_tuser,   // command, is_ipv6
  // stream out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // chosen_entry, status, pad
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // entries past what the 5-bit count can reach are never used
  localparam int DEPTH = (MAX_ENTRIES < 31) ? MAX_ENTRIES : 31;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SUM    = 7'b0000010,
    S_REVIVE = 7'b0000100,
    S_MOD    = 7'b0001000,
    S_WALK   = 7'b0010000,
    S_REPORT = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;

  // request registers
  logic [2*ADDR_W-1:0]  addr_sh;      // byte shift line, low byte first
  logic [ENTRY_W-1:0]   failed_q;
  logic [TIME_W-1:0]    now_q;

  // sequencer working registers
  logic [CNT_W-1:0]     byte_cnt;
  logic [HASH_W-1:0]    acc;
  logic [HASH_W-1:0]    hash_sh;
  logic [3:0]           bit_cnt;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     walk_i;
  logic [CNT_W-1:0]     n_q;
  logic [CNT_W-1:0]     pick;
  logic                 status_q;

  // configuration and entry state
  logic [CNT_W-1:0]     entry_count;
  logic [TIMEOUT_W-1:0] timeout;
  logic [CNT_W-1:0]     active_count;
  logic [CNT_W-1:0]     revive_ptr;
  logic [DEPTH-1:0]     disabled;
  logic [TIME_W-1:0]    until_time [DEPTH];

  // output register
  logic                 out_valid;
  logic [ENTRY_W-1:0]   out_chosen;
  logic                 out_status;

  logic [CNT_W-1:0]     used;
  logic [CNT_W-1:0]     cfg_used;
  logic [CNT_W-1:0]     failed_ext;
  logic                 failed_oor;
  logic [IDX_W-1:0]     failed_idx;
  logic [IDX_W-1:0]     walk_idx;
  logic [CNT_W-1:0]     rp;
  logic [CNT_W-1:0]     rp_inc;
  logic                 out_load;

  alu_op_t              alu_op;
  logic [ALU_W-1:0]     alu_a;
  logic [ALU_W-1:0]     alu_b;
  logic                 alu_bit;
  alu_res_t             alu_res;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = c;
    if (r == '0) begin
      r = CNT_W'(1);
    end
    if (r > DEPTH_C) begin
      r = DEPTH_C;
    end
    return r;
  endfunction

  assign used       = clamp_count(entry_count);
  assign cfg_used   = clamp_count(cfg_wdata[CNT_W-1:0]);
  assign failed_ext = {1'b0, failed_q};
  assign failed_oor = (failed_ext >= used);
  assign failed_idx = failed_oor ? '0 : failed_ext[IDX_W-1:0];
  assign walk_idx   = (walk_i < used) ? walk_i[IDX_W-1:0] : '0;

  // all-disabled revival pointer, out of range counts as first entry
  assign rp     = (revive_ptr >= used) ? '0 : revive_ptr;
  assign rp_inc = (rp + CNT_W'(1) >= used) ? '0 : rp + CNT_W'(1);

  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || m_tready);

  // shared unit operand select
  always_comb begin
    alu_op  = ALU_ADD;
    alu_a   = '0;
    alu_b   = '0;
    alu_bit = 1'b0;
    unique case (state)
      S_SUM: begin
        alu_op = ALU_ADD;
        alu_a  = ALU_W'(acc);
        alu_b  = ALU_W'(addr_sh[BYTE_W-1:0]);
      end
      S_MOD: begin
        alu_op  = ALU_REM;
        alu_a   = ALU_W'(rem);
        alu_b   = ALU_W'(active_count);
        alu_bit = hash_sh[HASH_W-1];
      end
      S_WALK: begin
        alu_op = ALU_GEQ;
        alu_a  = now_q;
        alu_b  = until_time[walk_idx];
      end
      S_REPORT: begin
        alu_op = ALU_ADD;
        alu_a  = now_q;
        alu_b  = ALU_W'(timeout);
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  ihbs_unit u_unit (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .bit_in (alu_bit),
    .res    (alu_res)
  );

  // until times need no reset: read only while the entry is disabled
  always_ff @(posedge clk) begin
    if (state == S_REPORT && !failed_oor && !disabled[failed_idx]) begin
      until_time[failed_idx] <= alu_res.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_count  <= RESET_ENTRY_COUNT;
      timeout      <= RESET_TIMEOUT;
      active_count <= clamp_count(RESET_ENTRY_COUNT);
      revive_ptr   <= '0;
      disabled     <= '0;
      out_valid    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            // addr_low bytes go first so ipv4 sums its four bytes
            addr_sh  <= {s_tdata[ADDR_W-1:0], s_tdata[2*ADDR_W-1:ADDR_W]};
            failed_q <= s_tdata[2*ADDR_W +: ENTRY_W];
            now_q    <= s_tdata[2*ADDR_W+ENTRY_W +: TIME_W];
            acc      <= '0;
            byte_cnt <= s_tuser[1] ? BYTES_V6 : BYTES_V4;
            status_q <= 1'b0;
            state    <= (s_tuser[0] == CMD_REPORT) ? S_REPORT : S_SUM;
          end
        end
        S_SUM: begin
          acc      <= alu_res.value[HASH_W-1:0];
          addr_sh  <= addr_sh >> BYTE_W;
          byte_cnt <= byte_cnt - CNT_W'(1);
          if (byte_cnt == CNT_W'(1)) begin
            state <= S_REVIVE;
          end
        end
        S_REVIVE: begin
          hash_sh <= acc;
          rem     <= '0;
          bit_cnt <= HASH_STEPS;
          if (active_count == '0) begin
            if (disabled[rp[IDX_W-1:0]]) begin
              disabled[rp[IDX_W-1:0]] <= 1'b0;
              active_count <= active_count + CNT_W'(1);
            end
            revive_ptr <= rp_inc;
          end
          state <= S_MOD;
        end
        S_MOD: begin
          rem     <= alu_res.value[CNT_W-1:0];
          hash_sh <= hash_sh << 1;
          bit_cnt <= bit_cnt - 4'd1;
          if (bit_cnt == 4'd1) begin
            n_q    <= (active_count == '0) ? '0 : alu_res.value[CNT_W-1:0];
            walk_i <= '0;
            state  <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_i >= used) begin
            // no pick found: last entry in use
            pick  <= used - CNT_W'(1);
            state <= S_DONE;
          end else if (disabled[walk_idx]) begin
            // timed-out entry comes back but is not counted in this walk
            if (alu_res.flag) begin
              disabled[walk_idx] <= 1'b0;
              active_count       <= active_count + CNT_W'(1);
            end
            walk_i <= walk_i + CNT_W'(1);
          end else if (n_q == '0) begin
            pick  <= walk_i;
            state <= S_DONE;
          end else begin
            n_q    <= n_q - CNT_W'(1);
            walk_i <= walk_i + CNT_W'(1);
          end
        end
        S_REPORT: begin
          pick     <= '0;
          status_q <= failed_oor;
          if (!failed_oor && !disabled[failed_idx]) begin
            disabled[failed_idx] <= 1'b1;
            if (active_count != '0) begin
              active_count <= active_count - CNT_W'(1);
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // output register
      if (out_load) begin
        out_valid  <= 1'b1;
        out_chosen <= pick[ENTRY_W-1:0];
        out_status <= status_q;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      // configuration writes are for the user to make only while idle; not enforced here
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENTRY_COUNT: begin
            entry_count  <= cfg_wdata[CNT_W-1:0];
            active_count <= cfg_used;
            revive_ptr   <= '0;
            for (int k = 0; k < DEPTH; k++) begin
              disabled[k] <= 1'b0;
            end
          end
          REG_DISABLE_TIMEOUT: begin
            timeout <= cfg_wdata;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'({out_status, out_chosen});

  // active count tracks enabled entries in use and never exceeds them
  a_active_bound: assert property (@(posedge clk) disable iff (rst)
    active_count <= used)
    else $error("active count beyond entries in use");

  // one request at a time: ready drops right after a request is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in work");

  // a result only appears from the final sequencer step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result raised outside final step");

endmodule

@@ hdl/ihbs_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihbs_unit
// shared add / restoring remainder step / unsigned compare unit
// ----------------------------------------------------------------------------
module ihbs_unit
  import ihbs_pkg::*;
(
  input  alu_op_t          op,
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  input  logic             bit_in,
  output alu_res_t         res
);

  logic [ALU_W-1:0] x;
  logic [ALU_W:0]   diff;
  logic [ALU_W-1:0] sum;
  logic             geq;

  // remainder step shifts the next dividend bit in before the trial subtract
  assign x    = (op == ALU_REM) ? {a[ALU_W-2:0], bit_in} : a;
  assign diff = {1'b0, x} - {1'b0, b};
  assign geq  = ~diff[ALU_W];
  assign sum  = a + b;

  always_comb begin
    unique case (op)
      ALU_ADD: begin
        res.value = sum;
        res.flag  = 1'b0;
      end
      ALU_REM: begin
        res.value = geq ? diff[ALU_W-1:0] : x;
        res.flag  = geq;
      end
      ALU_GEQ: begin
        res.value = diff[ALU_W-1:0];
        res.flag  = geq;
      end
      default: begin
        res.value = '0;
        res.flag  = 1'b0;
      end
    endcase
  end

endmodule
